/* rtl/lbd_pkg.sv */
// Package for the buffer directory: sizes, field widths, operation and status codes,
// controller states and the command and status records between controller and datapath.
// No dependencies.
package lbd_pkg;

   // Sizing of the directory.
   localparam int ENTRIES          = 32;
   localparam int DISK_BLOCK_COUNT = 8192;
   localparam int AGE_BITS         = 16;
   localparam int IDX_W            = $clog2(ENTRIES);

   // Request and response field widths.
   localparam int MODE_W          = 2;
   localparam int BLOCK_NUM_W     = 14;
   localparam int STATUS_W        = 2;
   localparam int ENTRY_INDEX_W   = 5;
   localparam int WB_BLOCK_W      = 13;
   localparam int REQ_DATA_W      = 16;
   localparam int RSP_DATA_W      = 24;

   // Stored block width; an in-bound block never needs more bits than this.
   localparam int STORE_W = ($clog2(DISK_BLOCK_COUNT) < BLOCK_NUM_W) ?
                            $clog2(DISK_BLOCK_COUNT) : BLOCK_NUM_W;
   // Width that holds any block number and the largest block count.
   localparam int BOUND_W = 17;

   localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

   // Operation codes.
   localparam logic [MODE_W-1:0] MODE_ALLOC      = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOOKUP     = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MARK_DIRTY = 2'd2;

   // Status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK            = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OUT_OF_BOUND  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_IN_BUFFER = 2'd2;

   typedef enum logic [1:0] {
      CTRL_IDLE,
      CTRL_SCAN,
      CTRL_COMMIT
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;      // capture a new request and clear the scan trackers
      logic scan_en;   // process the entry at the scan pointer
      logic commit;    // update the chosen entry and load the response register
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_of_bound;
      logic scan_last;
   } dp_status_type;

endpackage

/* rtl/lru_buffer_directory_core.sv */
// Top level of the buffer pool directory: controller and datapath.
// Depends on lbd_pkg, lbd_ctrl and lbd_datapath.
//
// Each request allocates, looks up or marks dirty a disk block in a 32-entry directory
// and yields exactly one response. A request is captured, then a scan over every entry
// ages the occupied entries on an allocation and finds a free entry, the oldest entry
// or the matching block, and then the commit step follows; an out-of-bound block skips
// the scan. Requests are taken one at a time; the next request is accepted while the
// previous response still waits in the output register, but its commit step waits
// until that response has been taken, so a stall on the response side can hold back
// the request behind it. Allocation replaces the entry allocated longest ago when no
// entry is free and reports a write-back when that entry was dirty.
module lru_buffer_directory_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // Fields from bit 0: mode [1:0], block_num [15:2].
   input  logic [lbd_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // Fields from bit 0: status [1:0], entry_index [6:2], writeback_valid [7],
   // writeback_block [20:8], zero fill [23:21].
   output logic [lbd_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import lbd_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type dp_status;

   lbd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (dp_status)
   );

   lbd_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (dp_status),
      .req_data (req_tdata),
      .rsp_data (rsp_tdata)
   );

endmodule

/* rtl/lbd_datapath.sv */
// Datapath of the buffer directory: entry storage, the entry scan with aging, free and
// victim search, the commit step and the response register.
// Depends on lbd_pkg.
module lbd_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  lbd_pkg::dp_cmd_type           cmd,
   output lbd_pkg::dp_status_type        status,
   input  logic [lbd_pkg::REQ_DATA_W-1:0] req_data,
   output logic [lbd_pkg::RSP_DATA_W-1:0] rsp_data
);
   import lbd_pkg::*;

   // Captured request.
   logic [MODE_W-1:0]      mode_ff, mode_in;
   logic [BLOCK_NUM_W-1:0] blk_ff, blk_in;

   // Scan pointer and trackers.
   logic [IDX_W-1:0]    scan_ff, scan_in;
   logic                found_ff, found_in;
   logic [IDX_W-1:0]    pick_ff, pick_in;
   logic [IDX_W-1:0]    vic_ff, vic_in;
   logic [AGE_BITS-1:0] best_ff, best_in;
   logic                wbd_ff, wbd_in;
   logic [STORE_W-1:0]  wbb_ff, wbb_in;

   // Entry state: flags in flip-flops, block and age in register arrays.
   logic [ENTRIES-1:0]  valid_ff, valid_in;
   logic [ENTRIES-1:0]  dirty_ff, dirty_in;
   logic [STORE_W-1:0]  block_mem [ENTRIES];
   logic [AGE_BITS-1:0] age_mem [ENTRIES];

   // Response register.
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [ENTRY_INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic                     rsp_wbv_ff, rsp_wbv_in;
   logic [WB_BLOCK_W-1:0]    rsp_wbb_ff, rsp_wbb_in;

   logic                out_of_bound;
   logic                is_alloc;
   logic                alloc_commit;
   logic                ent_valid;
   logic [STORE_W-1:0]  ent_block;
   logic [AGE_BITS-1:0] ent_age;
   logic [AGE_BITS-1:0] aged;
   logic [IDX_W-1:0]    commit_idx;
   logic                age_we;
   logic [IDX_W-1:0]    age_addr;
   logic [AGE_BITS-1:0] age_wdata;

   // Request decode.
   assign out_of_bound = BOUND_W'(blk_ff) >= BOUND_W'(DISK_BLOCK_COUNT);
   assign is_alloc     = (mode_ff == MODE_ALLOC);
   assign alloc_commit = cmd.commit && !out_of_bound && is_alloc;

   assign status.out_of_bound = out_of_bound;
   assign status.scan_last    = (scan_ff == IDX_W'(ENTRIES - 1));

   // Entry under the scan pointer, with its age after one saturating step.
   assign ent_valid = valid_ff[scan_ff];
   assign ent_block = block_mem[scan_ff];
   assign ent_age   = age_mem[scan_ff];
   assign aged      = (ent_valid && ent_age != AGE_MAX) ? ent_age + 1'b1 : ent_age;

   // On an allocation a free entry wins, else the oldest entry is replaced; a search uses its match.
   assign commit_idx = found_ff ? pick_ff : vic_ff;

   // Request capture and scan trackers.
   always_comb begin
      mode_in  = mode_ff;
      blk_in   = blk_ff;
      scan_in  = scan_ff;
      found_in = found_ff;
      pick_in  = pick_ff;
      vic_in   = vic_ff;
      best_in  = best_ff;
      wbd_in   = wbd_ff;
      wbb_in   = wbb_ff;
      if (cmd.load) begin
         mode_in  = req_data[MODE_W-1:0];
         blk_in   = req_data[MODE_W +: BLOCK_NUM_W];
         scan_in  = '0;
         found_in = 1'b0;
         pick_in  = '0;
         vic_in   = '0;
         best_in  = '0;
         wbd_in   = 1'b0;
      end else if (cmd.scan_en) begin
         scan_in = scan_ff + 1'b1;
         if (is_alloc) begin
            if (!found_ff && !ent_valid) begin
               found_in = 1'b1;
               pick_in  = scan_ff;
            end
            // Strictly greater keeps ties on the lowest index.
            if (ent_valid && aged > best_ff) begin
               best_in = aged;
               vic_in  = scan_ff;
               wbd_in  = dirty_ff[scan_ff];
               wbb_in  = ent_block;
            end
         end else if (!found_ff && ent_valid && ent_block == blk_ff[STORE_W-1:0]) begin
            found_in = 1'b1;
            pick_in  = scan_ff;
         end
      end
   end

   // Valid and dirty flags change only at commit.
   always_comb begin
      valid_in = valid_ff;
      dirty_in = dirty_ff;
      if (alloc_commit) begin
         valid_in[commit_idx] = 1'b1;
         dirty_in[commit_idx] = 1'b0;
      end else if (cmd.commit && !out_of_bound && mode_ff == MODE_MARK_DIRTY && found_ff) begin
         dirty_in[pick_ff] = 1'b1;
      end
   end

   // Age write port: aging during an allocation's scan, clearing at allocation.
   assign age_we    = (cmd.scan_en && is_alloc && ent_valid) || alloc_commit;
   assign age_addr  = alloc_commit ? commit_idx : scan_ff;
   assign age_wdata = alloc_commit ? '0 : aged;

   // Response fields.
   always_comb begin
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_wbv_in    = rsp_wbv_ff;
      rsp_wbb_in    = rsp_wbb_ff;
      if (cmd.commit) begin
         rsp_index_in = '0;
         rsp_wbv_in   = 1'b0;
         rsp_wbb_in   = '0;
         if (out_of_bound) begin
            rsp_status_in = STATUS_OUT_OF_BOUND;
         end else if (is_alloc || found_ff) begin
            rsp_status_in = STATUS_OK;
            rsp_index_in  = ENTRY_INDEX_W'(commit_idx);
            if (is_alloc && !found_ff && wbd_ff) begin
               rsp_wbv_in = 1'b1;
               rsp_wbb_in = WB_BLOCK_W'(wbb_ff);
            end
         end else begin
            rsp_status_in = STATUS_NOT_IN_BUFFER;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff  <= '0;
         found_ff <= 1'b0;
         pick_ff  <= '0;
         vic_ff   <= '0;
         valid_ff <= '0;
         dirty_ff <= '0;
      end else begin
         scan_ff  <= scan_in;
         found_ff <= found_in;
         pick_ff  <= pick_in;
         vic_ff   <= vic_in;
         valid_ff <= valid_in;
         dirty_ff <= dirty_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      blk_ff        <= blk_in;
      best_ff       <= best_in;
      wbd_ff        <= wbd_in;
      wbb_ff        <= wbb_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_wbv_ff    <= rsp_wbv_in;
      rsp_wbb_ff    <= rsp_wbb_in;
   end

   // Block and age storage.
   always_ff @(posedge clock) begin
      if (age_we) begin
         age_mem[age_addr] <= age_wdata;
      end
      if (alloc_commit) begin
         block_mem[commit_idx] <= blk_ff[STORE_W-1:0];
      end
   end

   assign rsp_data = {3'b000, rsp_wbb_ff, rsp_wbv_ff, rsp_index_ff, rsp_status_ff};

endmodule

/* rtl/lbd_ctrl.sv */
// Controller of the buffer directory: request and response handshakes and the
// sequence of load, scan and commit steps.
// Depends on lbd_pkg.
module lbd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output lbd_pkg::dp_cmd_type    cmd,
   input  lbd_pkg::dp_status_type status
);
   import lbd_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // State register and response valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTRL_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in    = state_ff;
      req_tready  = 1'b0;
      cmd.load    = 1'b0;
      cmd.scan_en = 1'b0;
      cmd.commit  = 1'b0;
      case (state_ff)
         CTRL_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = CTRL_SCAN;
            end
         end
         CTRL_SCAN: begin
            // An out-of-bound request touches no entry.
            cmd.scan_en = !status.out_of_bound;
            if (status.out_of_bound || status.scan_last) begin
               state_in = CTRL_COMMIT;
            end
         end
         CTRL_COMMIT: begin
            // Wait until the response register is free or its response is taken.
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.commit = 1'b1;
               state_in   = CTRL_IDLE;
            end
         end
         default: begin
            state_in = CTRL_IDLE;
         end
      endcase
   end

   // The response stays valid until it is taken.
   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

/* rtl/lbd_checker.sv */
// Port-level checks for the buffer pool directory, bound to the top level.
// Depends on lbd_pkg and lru_buffer_directory_core.
module lbd_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [lbd_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import lbd_pkg::*;

   // A stalled response keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // One request at a time: no request is taken right after another.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while one is in progress");

   // A failed request reports no entry and no write-back.
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != STATUS_OK |->
      rsp_tdata[6:2] == '0 && !rsp_tdata[7])
      else $error("failed request carries an entry or a write-back");

   // No response carries the spare status, and a write-back only comes with a successful request.
   a_wb_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
      (rsp_tdata[1:0] == STATUS_OK || rsp_tdata[1:0] == STATUS_OUT_OF_BOUND ||
       rsp_tdata[1:0] == STATUS_NOT_IN_BUFFER) &&
      (!rsp_tdata[7] || rsp_tdata[1:0] == STATUS_OK))
      else $error("bad status or write-back on a failed request");

endmodule

bind lru_buffer_directory_core lbd_checker u_lbd_checker (.*);

/* test/tb_top.sv */
// Testbench for lru_buffer_directory_core: a self-contained directory model predicts each
// response, and a checker compares responses field by field under random idling and stalls.
// Depends on lbd_pkg and the RTL of lru_buffer_directory_core.
`timescale 1ns / 100ps

module tb_top;
   import lbd_pkg::*;

   // Mode 3 is not an operation; the block treats it like a lookup.
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int IDLE_LIMIT   = 5000;
   localparam int SETTLE_CYCLES = 40;
   localparam int MAX_PRINTED  = 100;

   // One predicted response, kept as its separate fields.
   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic [ENTRY_INDEX_W-1:0] entry_index;
      logic                     writeback_valid;
      logic [WB_BLOCK_W-1:0]    writeback_block;
   } dir_reply_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   // Fields from bit 0: mode [1:0], block_num [15:2].
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // Fields from bit 0: status [1:0], entry_index [6:2], writeback_valid [7],
   // writeback_block [20:8], zero fill [23:21].
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // Directory contents as the testbench expects them.
   logic                  held_valid [ENTRIES];
   logic                  held_dirty [ENTRIES];
   logic [WB_BLOCK_W-1:0] held_block [ENTRIES];
   logic [AGE_BITS-1:0]   held_age   [ENTRIES];

   dir_reply_type predicted_replies[$];
   int            error_count;
   int            reply_count;
   int            send_idle_pct;
   int            recv_stall_pct;
   int            quiet_cycles;

   lru_buffer_directory_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one request to the expected directory and return the response it causes.
   function automatic dir_reply_type directory_update(input logic [MODE_W-1:0] mode,
                                                      input logic [BLOCK_NUM_W-1:0] blk);
      dir_reply_type       reply;
      int                  slot;
      logic [AGE_BITS-1:0] oldest_age;
      reply = '0;
      slot  = -1;
      if (blk >= DISK_BLOCK_COUNT) begin
         reply.status = STATUS_OUT_OF_BOUND;
      end else if (mode == MODE_ALLOC) begin
         // Every occupied entry grows one step older, saturating at the top.
         for (int i = 0; i < ENTRIES; i++)
            if (held_valid[i] && held_age[i] != AGE_MAX)
               held_age[i] = held_age[i] + 1'b1;
         for (int i = 0; i < ENTRIES; i++)
            if (slot < 0 && !held_valid[i])
               slot = i;
         // A full pool gives up its oldest entry, the lowest index on a tie.
         if (slot < 0) begin
            oldest_age = '0;
            slot = 0;
            for (int i = 0; i < ENTRIES; i++)
               if (held_age[i] > oldest_age) begin
                  oldest_age = held_age[i];
                  slot = i;
               end
            if (held_dirty[slot]) begin
               reply.writeback_valid = 1'b1;
               reply.writeback_block = held_block[slot];
            end
         end
         held_valid[slot] = 1'b1;
         held_dirty[slot] = 1'b0;
         held_block[slot] = blk[WB_BLOCK_W-1:0];
         held_age[slot]   = '0;
         reply.entry_index = slot[ENTRY_INDEX_W-1:0];
      end else begin
         // Lookup, mark dirty and the unused mode all search for the lowest match.
         for (int i = 0; i < ENTRIES; i++)
            if (slot < 0 && held_valid[i] && held_block[i] == blk[WB_BLOCK_W-1:0])
               slot = i;
         if (slot < 0) begin
            reply.status = STATUS_NOT_IN_BUFFER;
         end else begin
            reply.entry_index = slot[ENTRY_INDEX_W-1:0];
            if (mode == MODE_MARK_DIRTY)
               held_dirty[slot] = 1'b1;
         end
      end
      return reply;
   endfunction

   // Block number of a random occupied entry, or a random in-bound block if none is held.
   function automatic logic [BLOCK_NUM_W-1:0] pick_held_block();
      int held_count;
      int chosen;
      held_count = 0;
      for (int i = 0; i < ENTRIES; i++)
         if (held_valid[i])
            held_count++;
      if (held_count == 0)
         return BLOCK_NUM_W'($urandom_range(DISK_BLOCK_COUNT - 1));
      chosen = $urandom_range(held_count - 1);
      for (int i = 0; i < ENTRIES; i++)
         if (held_valid[i]) begin
            if (chosen == 0)
               return BLOCK_NUM_W'(held_block[i]);
            chosen--;
         end
      return '0;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      if (error_count < MAX_PRINTED)
         $display("%0t: response %0d: %s is %0d, expected %0d", $time, reply_count, what,
                  got, want);
      error_count++;
   endtask

   // Present one request after a random gap and wait until it is accepted.
   task automatic send_request(input logic [MODE_W-1:0] mode,
                               input logic [BLOCK_NUM_W-1:0] blk);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {blk, mode};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predicted_replies.push_back(directory_update(mode, blk));
   endtask

   // Hold off new requests until every predicted response has arrived.
   task automatic wait_for_replies();
      req_tvalid <= 1'b0;
      while (predicted_replies.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // In-bound block numbers and numbers at and beyond the disk size, for every mode.
   task automatic test_out_of_bound();
      send_request(MODE_ALLOC, 14'd0);
      send_request(MODE_ALLOC, BLOCK_NUM_W'(DISK_BLOCK_COUNT - 1));
      send_request(MODE_ALLOC, BLOCK_NUM_W'(DISK_BLOCK_COUNT));
      send_request(MODE_LOOKUP, 14'h3FFF);
      send_request(MODE_MARK_DIRTY, BLOCK_NUM_W'(DISK_BLOCK_COUNT));
      send_request(MODE_UNUSED, 14'h3FFF);
   endtask

   // Hits and misses for lookup, mark dirty and the unused mode.
   task automatic test_lookup_and_dirty();
      send_request(MODE_LOOKUP, 14'd0);
      send_request(MODE_LOOKUP, BLOCK_NUM_W'(DISK_BLOCK_COUNT - 1));
      send_request(MODE_LOOKUP, 14'd5);
      send_request(MODE_MARK_DIRTY, BLOCK_NUM_W'(DISK_BLOCK_COUNT - 1));
      send_request(MODE_MARK_DIRTY, 14'd77);
      send_request(MODE_UNUSED, 14'd0);
      send_request(MODE_UNUSED, 14'h0AAA);
   endtask

   // A block allocated twice gets a second entry; searches find the lower one.
   task automatic test_duplicate_blocks();
      send_request(MODE_ALLOC, 14'd0);
      send_request(MODE_LOOKUP, 14'd0);
      send_request(MODE_MARK_DIRTY, 14'd0);
      send_request(MODE_ALLOC, 14'h1555);
      send_request(MODE_LOOKUP, 14'h1555);
   endtask

   // Mixed traffic that fills the pool and keeps evicting clean and dirty entries.
   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input int count);
      int                     roll;
      logic [MODE_W-1:0]      mode;
      logic [BLOCK_NUM_W-1:0] blk;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count) begin
         roll = $urandom_range(99);
         if (roll < 5) begin
            mode = MODE_W'($urandom_range(3));
            blk  = BLOCK_NUM_W'($urandom_range((1 << BLOCK_NUM_W) - 1, DISK_BLOCK_COUNT));
         end else if (roll < 55) begin
            mode = MODE_ALLOC;
            blk  = ($urandom_range(99) < 15) ?
                   pick_held_block() : BLOCK_NUM_W'($urandom_range(DISK_BLOCK_COUNT - 1));
         end else begin
            if (roll < 72)
               mode = MODE_LOOKUP;
            else if (roll < 94)
               mode = MODE_MARK_DIRTY;
            else
               mode = MODE_UNUSED;
            blk = ($urandom_range(99) < 80) ?
                  pick_held_block() : BLOCK_NUM_W'($urandom_range(DISK_BLOCK_COUNT - 1));
         end
         send_request(mode, blk);
      end
      wait_for_replies();
   endtask

   // Receiver: random stalls, and each accepted response checked against the oldest prediction.
   always @(posedge clock) begin : check_replies
      dir_reply_type want;
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (predicted_replies.size() == 0) begin
            report_mismatch("unexpected response data", rsp_tdata, 0);
         end else begin
            want = predicted_replies.pop_front();
            if (rsp_tdata[1:0] != want.status)
               report_mismatch("status", rsp_tdata[1:0], want.status);
            if (rsp_tdata[6:2] != want.entry_index)
               report_mismatch("entry_index", rsp_tdata[6:2], want.entry_index);
            if (rsp_tdata[7] != want.writeback_valid)
               report_mismatch("writeback_valid", rsp_tdata[7], want.writeback_valid);
            if (rsp_tdata[20:8] != want.writeback_block)
               report_mismatch("writeback_block", rsp_tdata[20:8], want.writeback_block);
            if (rsp_tdata[23:21] != 3'd0)
               report_mismatch("zero fill", rsp_tdata[23:21], 0);
         end
         reply_count++;
      end
   end

   // Watchdog: ends the run when no request or response moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      rsp_tready     = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      error_count    = 0;
      reply_count    = 0;
      quiet_cycles   = 0;
      for (int i = 0; i < ENTRIES; i++) begin
         held_valid[i] = 1'b0;
         held_dirty[i] = 1'b0;
         held_block[i] = '0;
         held_age[i]   = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_out_of_bound();
      test_lookup_and_dirty();
      test_duplicate_blocks();
      wait_for_replies();

      // Idling phases: none, sender idle, receiver stalling, light idling on both sides.
      test_random_traffic(0, 0, 300);
      test_random_traffic(77, 0, 280);
      test_random_traffic(0, 77, 280);
      test_random_traffic(6, 6, 300);
      test_random_traffic(0, 0, 270);

      if (predicted_replies.size() != 0)
         report_mismatch("responses still missing", 0, predicted_replies.size());
      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

/* sim.f */
rtl/lbd_pkg.sv
rtl/lbd_datapath.sv
rtl/lbd_ctrl.sv
rtl/lru_buffer_directory_core.sv
rtl/lbd_checker.sv
test/tb_top.sv
